/* hdl/m31f_pkg.sv */
// ----------------------------------------------------------------------------
// m31f_pkg
// Shared types, constants and modular arithmetic for the Mersenne-31 cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package m31f_pkg;

  localparam logic [63:0] PI_SEED = 64'hC90FDAA22168C234;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } state_t;

  typedef enum logic [1:0] {
    CFG_KEY_A = 2'd0,
    CFG_KEY_B = 2'd1,
    CFG_KEY_C = 2'd2,
    CFG_KEY_D = 2'd3
  } cfg_idx_t;

  function automatic word_t madd(input word_t x, input word_t y);
    logic [32:0] s;
    s = {1'b0, x} + {1'b0, y};
    return {1'b0, s[30:0]} + {30'b0, s[32:31]};
  endfunction

  function automatic word_t fold2(input logic [63:0] x);
    logic [33:0] y;
    y = {3'b0, x[30:0]} + {1'b0, x[63:31]};
    return {1'b0, y[30:0]} + {29'b0, y[33:31]};
  endfunction

  function automatic state_t add_key(input state_t s, input state_t k);
    state_t r;
    r.a = madd(s.a, k.a);
    r.b = madd(s.b, k.b);
    r.c = madd(s.c, k.c);
    r.d = madd(s.d, k.d);
    return r;
  endfunction

  function automatic logic [63:0] pi_rot(input int unsigned rnd);
    logic [5:0] sh;
    sh = rnd[5:0];
    return (PI_SEED << sh) | (PI_SEED >> (7'd64 - {1'b0, sh}));
  endfunction

  function automatic logic [30:0] pi_c0(input int unsigned rnd);
    logic [63:0] w;
    w = pi_rot(rnd);
    return w[30:0];
  endfunction

  function automatic logic [30:0] pi_c1(input int unsigned rnd);
    logic [63:0] w;
    w = pi_rot(rnd);
    return w[62:32];
  endfunction

endpackage

`default_nettype wire

/* hdl/mersenne31_feistel_cipher.sv */
// ----------------------------------------------------------------------------
// mersenne31_feistel_cipher
// Mersenne-31 Feistel block cipher, fully unrolled and pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: four 31-bit plaintext words, one transaction per
//   cycle when in_stall is low. Output channel out_*: four 31-bit ciphertext
//   words, one result per input transaction, in order.
//   Key port cfg_*: write key word cfg_index with cfg_data when cfg_we is
//   high; write only while no transaction is in flight.
//   Pipeline: one key-add stage per step, six stages per round (each
//   squaring has a stage of its own) and the output register that also
//   does the final key add.
//   Throughput: one transaction per cycle while in_stall is low.
//   Reset: clears all valid bits and the key words to zero.
//   Receiver stall: the result holds in the output register; the pipeline
//   keeps advancing and takes input until a finished item reaches its last
//   stage, then everything holds and in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module mersenne31_feistel_cipher #(
  parameter int RND_PER_STEP = 4,
  parameter int STEP_COUNT   = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [30:0] in_plain_word_a,
  input  wire logic [30:0] in_plain_word_b,
  input  wire logic [30:0] in_plain_word_c,
  input  wire logic [30:0] in_plain_word_d,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      out_cipher_word_a,
  output logic [30:0]      out_cipher_word_b,
  output logic [30:0]      out_cipher_word_c,
  output logic [30:0]      out_cipher_word_d
);

  logic [30:0]      key_a_r, key_b_r, key_c_r, key_d_r;
  m31f_pkg::state_t key_w;

  m31f_pkg::state_t step_st [STEP_COUNT+1];
  logic [STEP_COUNT:0] step_vld;

  logic             adv;
  logic             out_vld_r;
  m31f_pkg::state_t out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= '0;
      key_b_r <= '0;
      key_c_r <= '0;
      key_d_r <= '0;
    end else if (cfg_we) begin
      unique case (m31f_pkg::cfg_idx_t'(cfg_index))
        m31f_pkg::CFG_KEY_A: key_a_r <= cfg_data;
        m31f_pkg::CFG_KEY_B: key_b_r <= cfg_data;
        m31f_pkg::CFG_KEY_C: key_c_r <= cfg_data;
        m31f_pkg::CFG_KEY_D: key_d_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign key_w = '{a: {1'b0, key_a_r}, b: {1'b0, key_b_r},
                   c: {1'b0, key_c_r}, d: {1'b0, key_d_r}};

  assign adv      = !(step_vld[STEP_COUNT] && out_vld_r && out_stall);
  assign in_stall = !adv;

  assign step_st[0] = '{a: {1'b0, in_plain_word_a}, b: {1'b0, in_plain_word_b},
                        c: {1'b0, in_plain_word_c}, d: {1'b0, in_plain_word_d}};
  assign step_vld[0] = in_valid;

  for (genvar st = 0; st < STEP_COUNT; st++) begin : g_step
    logic             key_vld_r;
    m31f_pkg::state_t key_st_r;
    m31f_pkg::state_t rnd_st [RND_PER_STEP+1];
    logic [RND_PER_STEP:0] rnd_vld;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        key_vld_r <= 1'b0;
      end else if (adv) begin
        key_vld_r <= step_vld[st];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        key_st_r <= m31f_pkg::add_key(step_st[st], key_w);
      end
    end

    assign rnd_st[0]  = key_st_r;
    assign rnd_vld[0] = key_vld_r;

    for (genvar r = 0; r < RND_PER_STEP; r++) begin : g_rnd
      m31f_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .c0        (m31f_pkg::pi_c0(st * RND_PER_STEP + r)),
        .c1        (m31f_pkg::pi_c1(st * RND_PER_STEP + r)),
        .in_valid  (rnd_vld[r]),
        .in_state  (rnd_st[r]),
        .out_valid (rnd_vld[r+1]),
        .out_state (rnd_st[r+1])
      );
    end

    assign step_st[st+1]  = rnd_st[RND_PER_STEP];
    assign step_vld[st+1] = rnd_vld[RND_PER_STEP];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && step_vld[STEP_COUNT]) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && step_vld[STEP_COUNT]) begin
      out_st_r <= m31f_pkg::add_key(step_st[STEP_COUNT], key_w);
    end
  end

  assign out_valid         = out_vld_r;
  assign out_cipher_word_a = out_st_r.a[30:0];
  assign out_cipher_word_b = out_st_r.b[30:0];
  assign out_cipher_word_c = out_st_r.c[30:0];
  assign out_cipher_word_d = out_st_r.d[30:0];

endmodule

`default_nettype wire

/* hdl/m31f_round.sv */
// ----------------------------------------------------------------------------
// m31f_round
// One Feistel round in six register stages: two squarings, each with its own
// stage, and the modular adds spread between them.
// ----------------------------------------------------------------------------
`default_nettype none

module m31f_round (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic [30:0]      c0,
  input  wire logic [30:0]      c1,
  input  wire logic             in_valid,
  input  wire m31f_pkg::state_t in_state,
  output logic                  out_valid,
  output m31f_pkg::state_t      out_state
);

  logic [5:0] vld_r;

  m31f_pkg::state_t s1_r, s2_r, s3_r, s4_r, s5_r, res_r, res_nxt;
  m31f_pkg::word_t  t1_r, t2_r, t3_r, t1_nxt;
  m31f_pkg::word_t  m3_r, m4_r, m5_r, m3_nxt;
  m31f_pkg::word_t  u4_r, u5_r, u4_nxt;
  m31f_pkg::word_t  f4_r, f5_r, f4_nxt;
  m31f_pkg::word_t  f1;
  logic [63:0]      p2_r, p2_nxt, q5_r, q5_nxt;

  always_comb begin
    t1_nxt = m31f_pkg::madd(in_state.b, {1'b0, c0});
    p2_nxt = {32'b0, t1_r} * {32'b0, t1_r};
    m3_nxt = m31f_pkg::fold2(p2_r + {32'b0, s2_r.a});
    u4_nxt = m31f_pkg::madd(t3_r, m3_r);
    f4_nxt = m31f_pkg::madd(u4_nxt, {1'b0, c1});
    q5_nxt = {32'b0, f4_r} * {32'b0, f4_r};
    f1     = m31f_pkg::fold2(q5_r + {32'b0, u5_r} + {32'b0, m5_r});
    res_nxt.a = m31f_pkg::madd(s5_r.c, f5_r);
    res_nxt.b = m31f_pkg::madd(s5_r.d, f1);
    res_nxt.c = s5_r.a;
    res_nxt.d = s5_r.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= in_state;
      t1_r  <= t1_nxt;
      s2_r  <= s1_r;
      t2_r  <= t1_r;
      p2_r  <= p2_nxt;
      s3_r  <= s2_r;
      t3_r  <= t2_r;
      m3_r  <= m3_nxt;
      s4_r  <= s3_r;
      m4_r  <= m3_r;
      u4_r  <= u4_nxt;
      f4_r  <= f4_nxt;
      s5_r  <= s4_r;
      m5_r  <= m4_r;
      u5_r  <= u4_r;
      f5_r  <= f4_r;
      q5_r  <= q5_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_valid = vld_r[5];
  assign out_state = res_r;

endmodule

`default_nettype wire

/* hdl/m31f_checker.sv */
// ----------------------------------------------------------------------------
// m31f_checker
// Port-level checks on the cipher's flow control, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module m31f_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [30:0] out_cipher_word_a,
  input wire logic [30:0] out_cipher_word_d
);

  a_stall_needs_blocked_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_free_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cipher_word_a)
                                  && $stable(out_cipher_word_d)))
    else $error("stalled result changed or vanished");

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind mersenne31_feistel_cipher m31f_checker u_m31f_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_cipher_word_a (out_cipher_word_a),
  .out_cipher_word_d (out_cipher_word_d)
);

`default_nettype wire
